>>> rtl/core/uer_pkg.sv
// Package for the ultrasonic echo ranger.
// Field widths, register indexes, reset values and the structs passed between stages.
// No dependencies.
`default_nettype none

package uer_pkg;

   localparam int TRIG_W     = 8;
   localparam int TMO_W      = 20;
   localparam int GAP_W      = 16;
   localparam int CNT_W      = 21;
   localparam int IDX_W      = 3;
   localparam int SUM_W      = 24;
   localparam int DIST_W     = 25;
   localparam int SUM17_W    = 29;
   localparam int RECIP_W    = SUM17_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int unsigned TICK_SCALE = 17;

   localparam logic [CSR_IDX_W-1:0] REG_TRIGGER_TICKS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ECHO_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_TICKS          = 2'd2;

   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST      = 8'd1;
   localparam logic [TMO_W-1:0]  ECHO_TIMEOUT_TICKS_RST = 20'd1000000;
   localparam logic [GAP_W-1:0]  GAP_TICKS_RST          = 16'd6000;

   typedef struct packed {
      logic [TRIG_W-1:0] trigger_ticks;
      logic [TMO_W-1:0]  echo_timeout_ticks;
      logic [GAP_W-1:0]  gap_ticks;
   } uer_cfg_type;

   typedef struct packed {
      logic             trigger;
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] sum;
   } uer_mid_type;

endpackage

`default_nettype wire

>>> rtl/core/uer_csr.sv
// Configuration registers of the echo ranger.
// Depends on uer_pkg.
`default_nettype none

module uer_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata,
   output uer_pkg::uer_cfg_type                cfg
);
   import uer_pkg::*;

   uer_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks      <= TRIGGER_TICKS_RST;
         cfg_ff.echo_timeout_ticks <= ECHO_TIMEOUT_TICKS_RST;
         cfg_ff.gap_ticks          <= GAP_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TRIGGER_TICKS:      cfg_ff.trigger_ticks      <= csr_wdata[TRIG_W-1:0];
            REG_ECHO_TIMEOUT_TICKS: cfg_ff.echo_timeout_ticks <= csr_wdata[TMO_W-1:0];
            REG_GAP_TICKS:          cfg_ff.gap_ticks          <= csr_wdata[GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/uer_ctrl.sv
// Input register and per-tick measurement sequencer of the echo ranger.
// Produces one stage word per tick: trigger, busy, done and the running sum.
// Depends on uer_pkg.
`default_nettype none

module uer_ctrl #(
   parameter int unsigned SAMPLES = 5
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           req_start_req,
   input  wire logic           req_echo,
   input  wire uer_pkg::uer_cfg_type cfg,
   input  wire logic           mid_ready,
   output logic                mid_valid,
   output uer_pkg::uer_mid_type mid
);
   import uer_pkg::*;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_TRIG  = 3'd1;
   localparam logic [2:0] PH_WAIT  = 3'd2;
   localparam logic [2:0] PH_COUNT = 3'd3;
   localparam logic [2:0] PH_GAP   = 3'd4;

   localparam logic [IDX_W:0] SAMPLE_COUNT = (IDX_W + 1)'(SAMPLES);

   logic             in_valid_ff;
   logic             in_start_ff;
   logic             in_echo_ff;
   logic             mid_valid_ff;
   uer_mid_type      mid_ff;
   uer_mid_type      mid_in;
   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_inc;
   logic [CNT_W-1:0] meas_cnt;
   logic             meas_end;
   logic             gap_end;
   logic             trig;
   logic             done;
   logic             mid_free;
   logic             in_free;
   logic             step;

   assign mid_free  = !mid_valid_ff || mid_ready;
   assign in_free   = !in_valid_ff || mid_free;
   assign req_stall = !in_free;
   assign step      = in_valid_ff && mid_free;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      trig     = 1'b0;
      done     = 1'b0;
      meas_end = 1'b0;
      meas_cnt = '0;
      gap_end  = 1'b0;

      if (phase_in == PH_IDLE && in_start_ff) begin
         phase_in = PH_TRIG;
         cnt_in   = '0;
         idx_in   = '0;
         sum_in   = '0;
      end

      cnt_inc = cnt_in + CNT_W'(1);

      case (phase_in)
         PH_IDLE: begin
         end
         PH_TRIG: begin
            trig = 1'b1;
            if (cnt_inc >= CNT_W'(cfg.trigger_ticks)) begin
               phase_in = PH_WAIT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_WAIT: begin
            if (in_echo_ff) begin
               phase_in = PH_COUNT;
               cnt_in   = CNT_W'(1);
               if (cfg.echo_timeout_ticks == '0) begin
                  meas_end = 1'b1;
                  meas_cnt = CNT_W'(1);
               end
            end
         end
         PH_COUNT: begin
            if (in_echo_ff) begin
               if (cnt_inc > CNT_W'(cfg.echo_timeout_ticks)) begin
                  meas_end = 1'b1;
                  meas_cnt = cnt_inc;
               end else begin
                  cnt_in = cnt_inc;
               end
            end else begin
               meas_end = 1'b1;
               meas_cnt = cnt_in;
            end
         end
         PH_GAP: begin
            if (cnt_inc >= CNT_W'(cfg.gap_ticks)) begin
               gap_end = 1'b1;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cnt_in   = '0;
         end
      endcase

      if (meas_end) begin
         sum_in   = sum_in + SUM_W'(meas_cnt);
         cnt_in   = '0;
         phase_in = PH_GAP;
         if (cfg.gap_ticks == '0) begin
            gap_end = 1'b1;
         end
      end

      if (gap_end) begin
         cnt_in = '0;
         if ({1'b0, idx_in} + (IDX_W + 1)'(1) >= SAMPLE_COUNT) begin
            done     = 1'b1;
            phase_in = PH_IDLE;
         end else begin
            idx_in   = idx_in + IDX_W'(1);
            phase_in = PH_TRIG;
         end
      end

      mid_in.trigger = trig;
      mid_in.busy    = (phase_in != PH_IDLE);
      mid_in.done    = done;
      mid_in.sum     = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (mid_free) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (step) begin
            phase_ff <= phase_in;
            cnt_ff   <= cnt_in;
            idx_ff   <= idx_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo;
      end
      if (step) begin
         mid_ff <= mid_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

`ifndef ASSERT_OFF
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && mid_ff.done |-> !mid_ff.busy)
      else $error("done word reports busy");

   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && mid_ff.trigger |-> mid_ff.busy)
      else $error("trigger driven while not busy");

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> cnt_ff == '0)
      else $error("tick count not cleared in idle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, idx_ff} < SAMPLE_COUNT)
      else $error("sample index beyond sample count");
`endif

endmodule

`default_nettype wire

>>> rtl/core/uer_scale.sv
// Averaging stage and result register of the echo ranger.
// Scales the tick sum to centi-cm by a constant reciprocal multiply; holds the distance.
// Depends on uer_pkg.
`default_nettype none

module uer_scale #(
   parameter int unsigned SAMPLES = 5
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        mid_valid,
   input  wire uer_pkg::uer_mid_type        mid,
   output logic                             mid_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_trigger,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [uer_pkg::DIST_W-1:0]       rsp_distance_centi_cm
);
   import uer_pkg::*;

   localparam int SHIFT  = SUM17_W + $clog2(SAMPLES);
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
   localparam int KMUL_W = RECIP_W + 5;
   localparam logic [KMUL_W-1:0] KMUL = KMUL_W'(64'(RECIP) * 64'(TICK_SCALE));
   localparam int PROD_W = SUM_W + KMUL_W;

   logic              out_valid_ff;
   logic              out_trigger_ff;
   logic              out_busy_ff;
   logic              out_done_ff;
   logic [DIST_W-1:0] dist_ff;
   logic [PROD_W-1:0] prod;
   logic [DIST_W-1:0] dist_in;
   logic              out_free;
   logic              load;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign mid_ready = out_free;
   assign load      = out_free && mid_valid;

   assign prod    = PROD_W'(mid.sum) * PROD_W'(KMUL);
   assign dist_in = prod[SHIFT +: DIST_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         dist_ff      <= '0;
      end else begin
         if (out_free) begin
            out_valid_ff <= mid_valid;
         end
         if (load && mid.done) begin
            dist_ff <= dist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_trigger_ff <= mid.trigger;
         out_busy_ff    <= mid.busy;
         out_done_ff    <= mid.done;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_trigger           = out_trigger_ff;
   assign rsp_busy_res          = out_busy_ff;
   assign rsp_done_res          = out_done_ff;
   assign rsp_distance_centi_cm = dist_ff;

`ifndef ASSERT_OFF
   a_dist_hold: assert property (@(posedge clock) disable iff (reset)
      !(load && mid.done) |=> $stable(dist_ff))
      else $error("distance changed without a done word");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: config registers, sequencer, averaging stage.
// Depends on uer_pkg, uer_csr, uer_ctrl and uer_scale.
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid / req_stall | start_req, echo (one 10 us tick)
//   rsp_    | out       | rsp_valid / rsp_stall | trigger, busy_res, done_res, distance
//   csr_    | in        | csr_wr_en             | csr_index, csr_wdata
//
// One word per clock in and out while rsp_stall is low; an accepted tick word is
// registered by the input, sequencer and averaging registers, the last with its multiply.
// Synchronous reset clears the pipeline valids, sequencer state and distance; presets CSRs.
// A stalled result holds every stage; with all three registers full, req_stall rises in
// the same cycle as rsp_stall.
`default_nettype none

module ultrasonic_echo_ranger #(
   parameter int unsigned SAMPLES = 5
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_start_req,
   input  wire logic                           req_echo,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_trigger,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [uer_pkg::DIST_W-1:0]          rsp_distance_centi_cm,
   input  wire logic                           csr_wr_en,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import uer_pkg::*;

   uer_cfg_type cfg;
   uer_mid_type mid;
   logic        mid_valid;
   logic        mid_ready;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uer_ctrl #(
      .SAMPLES (SAMPLES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_req (req_start_req),
      .req_echo      (req_echo),
      .cfg           (cfg),
      .mid_ready     (mid_ready),
      .mid_valid     (mid_valid),
      .mid           (mid)
   );

   uer_scale #(
      .SAMPLES (SAMPLES)
   ) u_scale (
      .clock                 (clock),
      .reset                 (reset),
      .mid_valid             (mid_valid),
      .mid                   (mid),
      .mid_ready             (mid_ready),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_trigger           (rsp_trigger),
      .rsp_busy_res          (rsp_busy_res),
      .rsp_done_res          (rsp_done_res),
      .rsp_distance_centi_cm (rsp_distance_centi_cm)
   );

endmodule

`default_nettype wire
